@@ rtl/sacs_pkg.sv @@
// ----------------------------------------------------------------------------
// sacs_pkg
// Shared types and codes for the set-associative LRU cache simulator: the
// access command, the result record, operation, outcome and register codes.
// ----------------------------------------------------------------------------
package sacs_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] address;
        logic [7:0]  access_size;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        second_hit;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } result_t;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_MISS     = 2'd1;
    localparam logic [1:0] OUT_EVICT    = 2'd2;
    localparam logic [1:0] OUT_OVERSIZE = 2'd3;

    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS       = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

    localparam int RAW_SETS = 128;

endpackage

@@ rtl/set_assoc_lru_cache_sim_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_top
// Tag-only set-associative cache with true LRU replacement, one trace access
// at a time, keeping running hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Usage:
//   An access is taken when start is high and busy is low; cmd carries the
//   operation, byte address and access size. One result per access appears
//   on result for a single cycle with done high; the receiver cannot stall,
//   so every result transfer completes in that cycle.
//   Configuration (set bits, ways, block bits) is written on the cfg channel,
//   which is always ready; write it only while the block is idle.
//   An oversize access or the unused operation code is answered directly:
//   done rises in the cycle after the accept and busy never rises.
//   An ordinary access reads one set row, then a single shared tag
//   comparator scans the ways one per cycle (stopping on a hit), then the row
//   is written back with updated LRU ages; a new access is taken only once
//   the block is back to idle.
//   After reset the set memory is swept clear, one set per cycle, across all
//   MAX_SETS sets with busy high; configuration writes are still taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_top
    import sacs_pkg::*;
#(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cmd_t       cmd,
    output logic       done,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W = WAY_W;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
        logic [MAX_WAYS-1:0][63:0]       tag;
    } row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t             state_reg;
    logic [SET_W-1:0]   clr_reg;
    cmd_t               cmd_reg;
    logic [63:0]        tag_reg;
    logic [SET_W-1:0]   set_reg;
    logic [WAY_W-1:0]   way_reg;
    logic               free_found_reg;
    logic [WAY_W-1:0]   free_way_reg;
    logic [WAY_W-1:0]   vict_way_reg;
    logic [AGE_W-1:0]   vict_age_reg;
    logic [WAY_W-1:0]   target_reg;
    logic [1:0]         kind_reg;
    logic [31:0]        hit_cnt_reg;
    logic [31:0]        miss_cnt_reg;
    logic [31:0]        evict_cnt_reg;
    logic [31:0]        hit_cnt_next;
    logic [31:0]        miss_cnt_next;
    logic [31:0]        evict_cnt_next;
    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    logic [2:0]         set_bits_reg;
    logic [3:0]         ways_reg;
    logic [2:0]         block_bits_reg;

    row_t               mem [MAX_SETS];
    row_t               rd_row_reg;
    row_t               new_row;

    logic [SET_W-1:0]   set_lut [RAW_SETS];
    logic [63:0]        addr_shift;
    logic [6:0]         set_mask;
    logic [6:0]         raw_set;
    logic [SET_W-1:0]   set_idx;
    logic [63:0]        tag_calc;
    logic [4:0]         ways_clamp;
    logic [WAY_W-1:0]   last_way;
    logic               accept;
    logic               oversize;
    logic               modify;
    logic               cur_valid;
    logic [AGE_W-1:0]   cur_age;
    logic               cur_hit;
    logic               cur_last;
    logic               vict_take;
    logic [AGE_W:0]     old_age;

    // set index folding onto the implemented sets
    for (genvar g = 0; g < RAW_SETS; g++)
    begin : g_set_lut
        assign set_lut[g] = SET_W'(g % MAX_SETS);
    end

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;
    assign modify    = (cmd_reg.operation == OP_MODIFY);
    assign oversize  = {1'b0, cmd.access_size} > (9'd1 << block_bits_reg);
    assign done_next = (accept && (oversize || (cmd.operation == OP_UNUSED))) ||
                       (state_reg == ST_UPDATE);

    // address split
    assign addr_shift = cmd_reg.address >> block_bits_reg;
    assign set_mask   = 7'((8'd1 << set_bits_reg) - 8'd1);
    assign raw_set    = addr_shift[6:0] & set_mask;
    assign set_idx    = set_lut[raw_set];
    assign tag_calc   = cmd_reg.address >> ({1'b0, set_bits_reg} + {1'b0, block_bits_reg});

    // ways in use, clamped to one .. MAX_WAYS
    always_comb
    begin
        ways_clamp = {1'b0, ways_reg};
        if (ways_clamp == 5'd0)
        begin
            ways_clamp = 5'd1;
        end
        else if (ways_clamp > 5'(MAX_WAYS))
        begin
            ways_clamp = 5'(MAX_WAYS);
        end
    end

    assign last_way = WAY_W'(ways_clamp - 5'd1);

    // shared way comparator
    assign cur_valid = rd_row_reg.valid[way_reg];
    assign cur_age   = rd_row_reg.age[way_reg];
    assign cur_hit   = cur_valid && (rd_row_reg.tag[way_reg] == tag_reg);
    assign cur_last  = (way_reg == last_way);
    assign vict_take = (way_reg == '0) || (cur_age > vict_age_reg);

    // lru update of the whole row
    always_comb
    begin
        new_row = rd_row_reg;
        if (kind_reg == OUT_HIT)
        begin
            old_age = {1'b0, rd_row_reg.age[target_reg]};
        end
        else
        begin
            old_age = (AGE_W+1)'(MAX_WAYS);
        end
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            if ((WAY_W'(j) != target_reg) && (WAY_W'(j) <= last_way) &&
                rd_row_reg.valid[j] && ({1'b0, rd_row_reg.age[j]} < old_age) &&
                (rd_row_reg.age[j] < AGE_W'(MAX_WAYS - 1)))
            begin
                new_row.age[j] = rd_row_reg.age[j] + AGE_W'(1);
            end
        end
        new_row.age[target_reg]   = '0;
        new_row.valid[target_reg] = 1'b1;
        new_row.tag[target_reg]   = tag_reg;
    end

    // running totals
    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        if (accept && oversize)
        begin
            miss_cnt_next = miss_cnt_reg + 32'd1;
        end
        else if (state_reg == ST_UPDATE)
        begin
            if (kind_reg == OUT_HIT)
            begin
                hit_cnt_next = hit_cnt_reg + 32'd1 + 32'(modify);
            end
            else
            begin
                hit_cnt_next  = hit_cnt_reg + 32'(modify);
                miss_cnt_next = miss_cnt_reg + 32'd1;
                if (kind_reg == OUT_EVICT)
                begin
                    evict_cnt_next = evict_cnt_reg + 32'd1;
                end
            end
        end
    end

    // set memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem[clr_reg] <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            mem[set_reg] <= new_row;
        end
        if (state_reg == ST_LOOKUP)
        begin
            rd_row_reg <= mem[set_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            cmd_reg        <= '0;
            tag_reg        <= '0;
            set_reg        <= '0;
            way_reg        <= '0;
            free_found_reg <= 1'b0;
            free_way_reg   <= '0;
            vict_way_reg   <= '0;
            vict_age_reg   <= '0;
            target_reg     <= '0;
            kind_reg       <= OUT_HIT;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            set_bits_reg   <= 3'd4;
            ways_reg       <= 4'd1;
            block_bits_reg <= 3'd4;
        end
        else
        begin
            done_reg      <= done_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                    REG_WAYS:       ways_reg       <= cfg_data;
                    REG_BLOCK_BITS: block_bits_reg <= cfg_data[2:0];
                    default:        ;
                endcase
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_reg == SET_W'(MAX_SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + SET_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= cmd;
                        if (oversize)
                        begin
                            result_reg.outcome        <= OUT_OVERSIZE;
                            result_reg.second_hit     <= 1'b0;
                            result_reg.hit_total      <= hit_cnt_next;
                            result_reg.miss_total     <= miss_cnt_next;
                            result_reg.eviction_total <= evict_cnt_next;
                        end
                        else if (cmd.operation == OP_UNUSED)
                        begin
                            result_reg.outcome        <= OUT_HIT;
                            result_reg.second_hit     <= 1'b0;
                            result_reg.hit_total      <= hit_cnt_next;
                            result_reg.miss_total     <= miss_cnt_next;
                            result_reg.eviction_total <= evict_cnt_next;
                        end
                        else
                        begin
                            state_reg <= ST_LOOKUP;
                        end
                    end
                end
                ST_LOOKUP:
                begin
                    tag_reg        <= tag_calc;
                    set_reg        <= set_idx;
                    way_reg        <= '0;
                    free_found_reg <= 1'b0;
                    state_reg      <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (cur_hit)
                    begin
                        target_reg <= way_reg;
                        kind_reg   <= OUT_HIT;
                        state_reg  <= ST_UPDATE;
                    end
                    else
                    begin
                        if (!free_found_reg && !cur_valid)
                        begin
                            free_found_reg <= 1'b1;
                            free_way_reg   <= way_reg;
                        end
                        if (vict_take)
                        begin
                            vict_way_reg <= way_reg;
                            vict_age_reg <= cur_age;
                        end
                        if (cur_last)
                        begin
                            state_reg <= ST_UPDATE;
                            if (free_found_reg)
                            begin
                                target_reg <= free_way_reg;
                                kind_reg   <= OUT_MISS;
                            end
                            else if (!cur_valid)
                            begin
                                target_reg <= way_reg;
                                kind_reg   <= OUT_MISS;
                            end
                            else
                            begin
                                target_reg <= vict_take ? way_reg : vict_way_reg;
                                kind_reg   <= OUT_EVICT;
                            end
                        end
                        else
                        begin
                            way_reg <= way_reg + WAY_W'(1);
                        end
                    end
                end
                ST_UPDATE:
                begin
                    result_reg.outcome        <= kind_reg;
                    result_reg.second_hit     <= modify;
                    result_reg.hit_total      <= hit_cnt_next;
                    result_reg.miss_total     <= miss_cnt_next;
                    result_reg.eviction_total <= evict_cnt_next;
                    state_reg                 <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a result transfer only happens with the block idle
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy)
        else $error("result strobe while busy");

    // the way scan never runs past the ways in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (way_reg <= last_way))
        else $error("way scan out of range");

    // every row write-back is followed by a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> done_reg)
        else $error("missing result after update");

    // totals only move together with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        ((hit_cnt_reg != $past(hit_cnt_reg)) || (miss_cnt_reg != $past(miss_cnt_reg)) ||
         (evict_cnt_reg != $past(evict_cnt_reg))) |-> done_reg)
        else $error("totals changed without a result");

endmodule
